// File: rtl/wsd_pkg.sv
package wsd_pkg;

   // length codes of the second header byte
   localparam logic [6:0] LEN_EXT16 = 7'd126;
   localparam logic [6:0] LEN_EXT64 = 7'd127;

   // opcodes
   localparam logic [3:0] OP_DATA_MAX = 4'h2;
   localparam logic [3:0] OP_CLOSE    = 4'h8;

   // extended length and mask key byte counts, minus one
   localparam logic [2:0] EXT16_LAST = 3'd1;
   localparam logic [2:0] EXT64_LAST = 3'd7;
   localparam logic [2:0] KEY_LAST   = 3'd3;

   // one result word from the parser stage
   typedef struct packed {
      logic       has;
      logic [7:0] payload_byte;
      logic       payload_valid;
      logic       frame_end;
      logic       frame_final;
      logic [1:0] frame_kind;
      logic       closed;
   } wsd_result_type;

endpackage

// File: rtl/wsd_parser.sv
module wsd_parser (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    step,
   input  logic [7:0]              data_byte,
   output wsd_pkg::wsd_result_type result
);

   typedef enum logic [2:0] {
      PH_HDR0    = 3'd0,
      PH_HDR1    = 3'd1,
      PH_EXTLEN  = 3'd2,
      PH_MASK    = 3'd3,
      PH_PAYLOAD = 3'd4,
      PH_CLOSED  = 3'd5
   } phase_type;

   phase_type   phase_ff, phase_in;
   logic        fin_ff, fin_in;
   logic [3:0]  opcode_ff, opcode_in;
   logic        mask_ff, mask_in;
   logic [63:0] len_ff, len_in;
   logic [2:0]  hcnt_ff, hcnt_in;
   logic [31:0] key_ff, key_in;
   logic [1:0]  midx_ff, midx_in;

   logic        len_done;
   logic        hdr_done;
   logic        is_data;
   logic [7:0]  key_byte;

   assign is_data = (opcode_ff <= wsd_pkg::OP_DATA_MAX);

   // mask key byte for this payload position, first key byte at the top
   always_comb begin
      case (midx_ff)
         2'd0:    key_byte = key_ff[31:24];
         2'd1:    key_byte = key_ff[23:16];
         2'd2:    key_byte = key_ff[15:8];
         default: key_byte = key_ff[7:0];
      endcase
   end

   // next state and result for the byte at the parser input
   always_comb begin
      phase_in  = phase_ff;
      fin_in    = fin_ff;
      opcode_in = opcode_ff;
      mask_in   = mask_ff;
      len_in    = len_ff;
      hcnt_in   = hcnt_ff;
      key_in    = key_ff;
      midx_in   = midx_ff;
      len_done  = 1'b0;
      hdr_done  = 1'b0;
      result    = '0;

      case (phase_ff)
         PH_CLOSED: begin
         end
         PH_HDR1: begin
            mask_in = data_byte[7];
            len_in  = '0;
            if (data_byte[6:0] == wsd_pkg::LEN_EXT16) begin
               phase_in = PH_EXTLEN;
               hcnt_in  = wsd_pkg::EXT16_LAST;
            end else if (data_byte[6:0] == wsd_pkg::LEN_EXT64) begin
               phase_in = PH_EXTLEN;
               hcnt_in  = wsd_pkg::EXT64_LAST;
            end else begin
               len_in   = {57'd0, data_byte[6:0]};
               len_done = 1'b1;
            end
         end
         PH_EXTLEN: begin
            len_in = {len_ff[55:0], data_byte};
            if (hcnt_ff == 3'd0) begin
               len_done = 1'b1;
            end else begin
               hcnt_in = hcnt_ff - 3'd1;
            end
         end
         PH_MASK: begin
            key_in = {key_ff[23:0], data_byte};
            if (hcnt_ff == 3'd0) begin
               hdr_done = 1'b1;
            end else begin
               hcnt_in = hcnt_ff - 3'd1;
            end
         end
         PH_PAYLOAD: begin
            midx_in = midx_ff + 2'd1;
            len_in  = len_ff - 64'd1;
            if (is_data) begin
               result.has           = 1'b1;
               result.payload_byte  = data_byte ^ key_byte;
               result.payload_valid = 1'b1;
               result.frame_end     = (len_in == 64'd0);
               result.frame_final   = fin_ff;
               result.frame_kind    = opcode_ff[1:0];
            end
            if (len_in == 64'd0) begin
               if (!is_data && opcode_ff == wsd_pkg::OP_CLOSE) begin
                  phase_in      = PH_CLOSED;
                  result.has    = 1'b1;
                  result.closed = 1'b1;
               end else begin
                  phase_in = PH_HDR0;
               end
            end
         end
         default: begin
            fin_in    = data_byte[7];
            opcode_in = data_byte[3:0];
            phase_in  = PH_HDR1;
         end
      endcase

      // length complete: collect the key or close the header
      if (len_done) begin
         key_in = '0;
         if (mask_in) begin
            phase_in = PH_MASK;
            hcnt_in  = wsd_pkg::KEY_LAST;
         end else begin
            hdr_done = 1'b1;
         end
      end

      // header complete: enter payload or finish an empty frame
      if (hdr_done) begin
         midx_in = 2'd0;
         if (len_in != 64'd0) begin
            phase_in = PH_PAYLOAD;
         end else if (opcode_ff == wsd_pkg::OP_CLOSE) begin
            phase_in      = PH_CLOSED;
            result.has    = 1'b1;
            result.closed = 1'b1;
         end else begin
            phase_in = PH_HDR0;
            if (is_data) begin
               result.has         = 1'b1;
               result.frame_end   = 1'b1;
               result.frame_final = fin_ff;
               result.frame_kind  = opcode_ff[1:0];
            end
         end
      end
   end

   // parser state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_HDR0;
         fin_ff    <= 1'b0;
         opcode_ff <= 4'd0;
         mask_ff   <= 1'b0;
         len_ff    <= 64'd0;
         hcnt_ff   <= 3'd0;
         key_ff    <= 32'd0;
         midx_ff   <= 2'd0;
      end else if (step) begin
         phase_ff  <= phase_in;
         fin_ff    <= fin_in;
         opcode_ff <= opcode_in;
         mask_ff   <= mask_in;
         len_ff    <= len_in;
         hcnt_ff   <= hcnt_in;
         key_ff    <= key_in;
         midx_ff   <= midx_in;
      end
   end

endmodule

// File: rtl/websocket_frame_deframer_top.sv
// WebSocket receive deframer.
// The req channel takes the raw stream one byte per word (req_data_byte).
// The rsp channel gives unmasked payload bytes of data frames, each tagged
// with the frame's FIN bit and opcode; rsp_frame_end marks the last byte, or
// a lone marker word for an empty data frame. Control frames give nothing,
// except that a close frame gives one word with rsp_closed set once it has
// been fully consumed; after it every byte is taken and dropped.
// A byte enters the input register on acceptance and its result is written
// into the output register when the parser steps on it. Throughput: one byte
// per cycle while no result waits on a stalled receiver; the whole header and
// payload step is one pass through the parser between the two registers.
// Reset empties both registers and readies the parser for a first header byte.
// When the receiver stalls, the result word holds; bytes that give no result
// still drain, and req_ready drops only while a result is waiting and the
// input register is full.
module websocket_frame_deframer_top (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_data_byte,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_payload_byte,
   output logic       rsp_payload_valid,
   output logic       rsp_frame_end,
   output logic       rsp_frame_final,
   output logic [1:0] rsp_frame_kind,
   output logic       rsp_closed
);

   logic                    in_valid_ff, in_valid_in;
   logic [7:0]              in_byte_ff;
   logic                    out_valid_ff, out_valid_in;
   wsd_pkg::wsd_result_type out_ff;
   wsd_pkg::wsd_result_type res;
   logic                    step;

   // the parser steps when its result, if any, has a free slot
   assign step      = in_valid_ff && (!out_valid_ff || rsp_ready || !res.has);
   assign req_ready = !in_valid_ff || step;

   wsd_parser u_parser (
      .clock     (clock),
      .reset     (reset),
      .step      (step),
      .data_byte (in_byte_ff),
      .result    (res)
   );

   // input register
   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_valid && req_ready) begin
         in_valid_in = 1'b1;
      end else if (step) begin
         in_valid_in = 1'b0;
      end
   end

   // output register
   always_comb begin
      out_valid_in = out_valid_ff;
      if (step && res.has) begin
         out_valid_in = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_byte_ff <= req_data_byte;
      end
      if (step && res.has) begin
         out_ff <= res;
      end
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_payload_byte  = out_ff.payload_byte;
   assign rsp_payload_valid = out_ff.payload_valid;
   assign rsp_frame_end     = out_ff.frame_end;
   assign rsp_frame_final   = out_ff.frame_final;
   assign rsp_frame_kind    = out_ff.frame_kind;
   assign rsp_closed        = out_ff.closed;

endmodule

// File: rtl/wsd_checker.sv
module wsd_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] rsp_payload_byte,
   input logic       rsp_payload_valid,
   input logic       rsp_frame_end,
   input logic       rsp_frame_final,
   input logic [1:0] rsp_frame_kind,
   input logic       rsp_closed
);

   // a stalled result word holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload_byte)
         && $stable(rsp_closed) && $stable(rsp_frame_end))
      else $error("stalled rsp word changed");

   // the close word carries nothing else
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_closed |-> !rsp_payload_valid && !rsp_frame_end
         && !rsp_frame_final && rsp_frame_kind == 2'd0 && rsp_payload_byte == 8'd0)
      else $error("close word has frame fields set");

   // a word without payload is an empty frame marker or the close word
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_payload_valid |-> rsp_payload_byte == 8'd0
         && (rsp_frame_end || rsp_closed) && rsp_frame_kind != 2'd3)
      else $error("bad marker word");

   // nothing follows the close word
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && rsp_closed |=> !rsp_valid)
      else $error("word after close");

endmodule

bind websocket_frame_deframer_top wsd_checker u_wsd_checker (
   .clock             (clock),
   .reset             (reset),
   .rsp_valid         (rsp_valid),
   .rsp_ready         (rsp_ready),
   .rsp_payload_byte  (rsp_payload_byte),
   .rsp_payload_valid (rsp_payload_valid),
   .rsp_frame_end     (rsp_frame_end),
   .rsp_frame_final   (rsp_frame_final),
   .rsp_frame_kind    (rsp_frame_kind),
   .rsp_closed        (rsp_closed)
);
